// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ABS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/core/abs_pkg.sv =====
// Shared constants, state type and cell status type of the allocation shadow bitmap.
`timescale 1ns / 1ps
`default_nettype none

package abs_pkg;

    localparam int REGION_BYTES     = 65536;
    localparam int GRAIN_BYTES      = 32 / 8;
    localparam int REGIONS          = 16;
    localparam int ADDR_BITS        = 48;

    localparam int REGION_LOG2      = $clog2(REGION_BYTES);
    localparam int GRAIN_LOG2       = $clog2(GRAIN_BYTES);
    localparam int MARK_WORD_BITS   = 32;
    localparam int BIT_SEL_W        = $clog2(MARK_WORD_BITS);
    localparam int WORDS_PER_REGION = REGION_BYTES / GRAIN_BYTES / MARK_WORD_BITS;
    localparam int WORD_SEL_W       = $clog2(WORDS_PER_REGION);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } abs_state_t;

    // Status that one region cell reports to the rest of the block.
    typedef struct packed {
        logic valid;
        logic hit;
    } abs_cell_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/abs_region_cell.sv =====
// One cell of the region table: holds one region tag and its valid bit.
`timescale 1ns / 1ps
`default_nettype none

module abs_region_cell #(
    parameter int TAG_W = abs_pkg::ADDR_BITS - abs_pkg::REGION_LOG2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [TAG_W-1:0]       tag,
    input  wire logic                   prev_valid,
    input  wire logic                   claim,
    output abs_pkg::abs_cell_stat_t     stat
);

    logic             valid_reg;
    logic             valid_next;
    logic [TAG_W-1:0] base_reg;
    logic [TAG_W-1:0] base_next;
    logic             take;

    // The first free cell is the one whose left neighbor is already taken.
    assign take = claim && prev_valid && !valid_reg;

    always_comb
    begin
        valid_next = valid_reg | take;
        base_next  = take ? tag : base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
    end

    assign stat.valid = valid_reg;
    assign stat.hit   = valid_reg && (base_reg == tag);

endmodule

`default_nettype wire

// ===== rtl/core/abs_mark_ram.sv =====
// Mark bitmap storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module abs_mark_ram #(
    parameter int DEPTH = abs_pkg::REGIONS * abs_pkg::WORDS_PER_REGION,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = abs_pkg::MARK_WORD_BITS
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/allocation_shadow_bitmap.sv =====
// Top level of the allocation shadow bitmap: region cell chain, mark RAM and control.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Allocation shadow bitmap. The block keeps one mark bit for every 4-byte aligned
// address of the heap, grouped in 64 KiB regions. A command word (address, mode)
// is taken at a rising edge where start is high and busy is low; mode 0 marks the
// address allocated, mode 1 marks it released. Exactly one result word follows:
// done is a one-cycle strobe in the cycle after the update cycle, and the result
// ports are valid only in that cycle. The receiver cannot hold results off, so it
// must take every word in the cycle it is shown. The region lookup and the RAM
// read address are formed in the accepting cycle, and the bitmap read-modify-write
// on the single-port-per-direction mark RAM takes the following cycle, the update
// cycle, in which busy is high; a new command may start in the cycle in which the
// previous result is shown. The region table is a row of REGIONS cells; each
// compares its stored region tag with the incoming one and passes its valid bit
// to its right neighbor, which is how the next free entry is found. Entries are
// claimed in order and never released. After reset the block sweeps the mark RAM
// to zero, one word per cycle, and holds busy high until all REGIONS * 512 words
// (8192 with the default sizing) are cleared, before the first command is taken.
// A misaligned address is flagged and changes nothing; an allocation that needs a
// new region while all entries are taken is flagged in table_full and is not
// recorded; a release of an unmarked address, including one in no known region,
// sets bad_release.
module allocation_shadow_bitmap #(
    parameter int REGIONS   = abs_pkg::REGIONS,
    parameter int ADDR_BITS = abs_pkg::ADDR_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [ADDR_BITS-1:0] address,
    input  wire logic                 mode,
    output logic                      done,
    output logic                      old_mark,
    output logic                      bad_release,
    output logic                      misaligned,
    output logic                      table_full
);

    localparam int TAG_W     = ADDR_BITS - abs_pkg::REGION_LOG2;
    localparam int ENTRY_W   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int MEM_DEPTH = REGIONS * abs_pkg::WORDS_PER_REGION;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int DW        = abs_pkg::MARK_WORD_BITS;
    localparam int BW        = abs_pkg::BIT_SEL_W;
    localparam int GL        = abs_pkg::GRAIN_LOG2;

    // Address fields.
    logic [TAG_W-1:0]                  tag_in;
    logic [abs_pkg::WORD_SEL_W-1:0]    word_in;
    logic [BW-1:0]                     bit_in;
    logic                              aligned;
    logic                              accept;

    // Region cell chain.
    abs_pkg::abs_cell_stat_t           stat [REGIONS];
    logic [REGIONS-1:0]                valid_vec;
    logic [REGIONS-1:0]                hit_vec;
    logic [REGIONS-1:0]                prev_vec;
    logic [ENTRY_W-1:0]                hit_idx;
    logic [ENTRY_W-1:0]                claim_idx;
    logic [ENTRY_W-1:0]                entry_sel;
    logic                              any_hit;
    logic                              full;
    logic                              claim;
    logic                              access;
    logic [REGIONS:0]                  thermo_chk;

    // Control and command registers.
    abs_pkg::abs_state_t               state_reg;
    abs_pkg::abs_state_t               state_next;
    logic [MEM_AW-1:0]                 clr_cnt_reg;
    logic [MEM_AW-1:0]                 clr_cnt_next;
    logic                              clr_last;
    logic                              mode_reg;
    logic [BW-1:0]                     bit_reg;
    logic [MEM_AW-1:0]                 waddr_reg;
    logic                              mis_reg;
    logic                              full_reg;
    logic                              access_reg;

    // Mark RAM ports.
    logic                              mem_we;
    logic [MEM_AW-1:0]                 mem_waddr;
    logic [DW-1:0]                     mem_wdata;
    logic                              mem_re;
    logic [MEM_AW-1:0]                 mem_raddr;
    logic [DW-1:0]                     mem_rdata;

    // Update path and result registers.
    logic [DW-1:0]                     bit_mask;
    logic                              old_bit;
    logic [DW-1:0]                     new_word;
    logic                              done_reg;
    logic                              old_mark_reg;
    logic                              bad_release_reg;
    logic                              misaligned_reg;
    logic                              table_full_reg;

    assign tag_in  = address[ADDR_BITS-1:abs_pkg::REGION_LOG2];
    assign word_in = address[abs_pkg::REGION_LOG2-1:GL+BW];
    assign bit_in  = address[GL+BW-1:GL];
    assign aligned = (address[GL-1:0] == '0);
    assign accept  = start && !busy;

    // The chain of region cells. Cell zero always sees a taken neighbor, so
    // the first claim lands there.
    for (genvar gi = 0; gi < REGIONS; gi++)
    begin : g_cell
        if (gi == 0)
        begin : g_head
            assign prev_vec[gi] = 1'b1;
        end
        else
        begin : g_link
            assign prev_vec[gi] = stat[gi-1].valid;
        end

        abs_region_cell #(
            .TAG_W      (TAG_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .tag        (tag_in),
            .prev_valid (prev_vec[gi]),
            .claim      (claim),
            .stat       (stat[gi])
        );

        assign valid_vec[gi] = stat[gi].valid;
        assign hit_vec[gi]   = stat[gi].hit;
    end

    // Tags in the table are unique, so at most one cell hits and the index can
    // be formed by OR-ing; likewise only one cell sits at the free boundary.
    always_comb
    begin
        hit_idx   = '0;
        claim_idx = '0;
        for (int i = 0; i < REGIONS; i++)
        begin
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | ENTRY_W'(i);
            end
            if (prev_vec[i] && !valid_vec[i])
            begin
                claim_idx = claim_idx | ENTRY_W'(i);
            end
        end
    end

    assign any_hit    = |hit_vec;
    assign full       = valid_vec[REGIONS-1];
    assign entry_sel  = any_hit ? hit_idx : claim_idx;
    assign claim      = accept && aligned && !any_hit && !mode;
    assign access     = aligned && (any_hit || (!mode && !full));
    assign mem_raddr  = (MEM_AW'(entry_sel) << abs_pkg::WORD_SEL_W) | MEM_AW'(word_in);
    assign thermo_chk = {1'b0, valid_vec} + (REGIONS + 1)'(1);

    assign clr_last   = (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            abs_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = abs_pkg::ST_IDLE;
                end
            end
            abs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = abs_pkg::ST_UPDATE;
                end
            end
            abs_pkg::ST_UPDATE:
            begin
                state_next = abs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = abs_pkg::ST_CLEAR;
            end
        endcase
    end

    // Bitmap update: the read word arrived at the start of the update cycle.
    assign bit_mask = DW'(1) << bit_reg;
    assign old_bit  = access_reg && ((mem_rdata & bit_mask) != '0);
    assign new_word = mode_reg ? (mem_rdata & ~bit_mask) : (mem_rdata | bit_mask);

    // State outputs.
    always_comb
    begin
        busy         = 1'b1;
        mem_we       = 1'b0;
        mem_waddr    = waddr_reg;
        mem_wdata    = new_word;
        mem_re       = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            abs_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
            end
            abs_pkg::ST_IDLE:
            begin
                busy   = 1'b0;
                mem_re = start;
            end
            abs_pkg::ST_UPDATE:
            begin
                mem_we = access_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    abs_mark_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW),
        .DW    (DW)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= abs_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= (state_reg == abs_pkg::ST_UPDATE);
        end
    end

    // Command and result words carry no reset; done qualifies them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            bit_reg    <= bit_in;
            waddr_reg  <= mem_raddr;
            mis_reg    <= !aligned;
            full_reg   <= aligned && !any_hit && !mode && full;
            access_reg <= access;
        end
        if (state_reg == abs_pkg::ST_UPDATE)
        begin
            old_mark_reg    <= old_bit;
            bad_release_reg <= mode_reg && !mis_reg && !old_bit;
            misaligned_reg  <= mis_reg;
            table_full_reg  <= full_reg;
        end
    end

    assign done        = done_reg;
    assign old_mark    = old_mark_reg;
    assign bad_release = bad_release_reg;
    assign misaligned  = misaligned_reg;
    assign table_full  = table_full_reg;

    // A taken command always leads into the update state, and that state yields a result.
    `ABS_ASSERT_NEXT(a_accept_update, clk, rst_n, accept, state_reg == abs_pkg::ST_UPDATE)
    `ABS_ASSERT_NEXT(a_update_done, clk, rst_n, state_reg == abs_pkg::ST_UPDATE, done)
    // Entries are claimed strictly in order, so the valid bits form a thermometer.
    `ABS_ASSERT_IMP(a_valid_thermo, clk, rst_n, 1'b1, $onehot(thermo_chk))
    // At most one of the exception flags can be raised in a result.
    `ABS_ASSERT_IMP(a_flags_excl, clk, rst_n, done, $onehot0({misaligned, table_full, bad_release}))

endmodule

`default_nettype wire
